// ===== rtl/mlc_pkg.sv =====
// ----------------------------------------------------------------------------
// mlc_pkg
// Shared types, codes and constants of the mean luminance contrast engine.
// ----------------------------------------------------------------------------
package mlc_pkg;

	// item modes
	localparam logic [1:0] ModeMeasure = 2'd0;
	localparam logic [1:0] ModeFinish  = 2'd1;
	localparam logic [1:0] ModeApply   = 2'd2;

	// configuration port
	localparam int         AddrW           = 3;
	localparam logic       RegContrastGain = 1'b0;
	localparam logic [15:0] GainReset      = 16'sd256;

	// measurement storage
	localparam int          SumW      = 32;
	localparam int          CountW    = 25;
	localparam logic [24:0] MaxBytes  = 25'd16777216;
	localparam int          MeanW     = 10;
	localparam logic [9:0]  MeanReset = 10'd128;
	localparam logic [9:0]  MeanMax   = 10'd1023;

	// luminance weights
	localparam logic [7:0] WeightR = 8'd54;
	localparam logic [7:0] WeightG = 8'd183;
	localparam logic [7:0] WeightB = 8'd19;

	// weighted numerator and divisor floor(256*count/3) = 85*count + floor(count/3)
	localparam int          NumW        = 40;
	localparam int          DenW        = 31;
	localparam int          RemW        = 32;
	localparam logic [6:0]  Mul85       = 7'd85;
	localparam logic [23:0] Recip3      = 24'd11184811;  // (2^25 + 1) / 3
	localparam int          Recip3Shift = 25;
	localparam int          RecW        = 49;

	// divider iterations, one quotient bit each
	localparam int         StepW    = 6;
	localparam logic [5:0] DivLast  = 6'd39;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NUM0,
		ST_NUM1,
		ST_NUM2,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic       take;      // request accepted this cycle
		logic       rec_load;  // count times reciprocal of three
		logic       den_load;  // divisor assembly
		logic       acc_load;  // first weighted product
		logic       acc_add;   // add further weighted product
		logic [1:0] chan_sel;  // channel sum into the shared multiplier
		logic       div_load;
		logic       div_step;
		logic       finish;    // store mean, clear measurement
		logic       push;      // result into output queue
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic count_zero;
	} status_t;

	typedef struct packed {
		logic [7:0]       mapped;
		logic [MeanW-1:0] mean;
		logic             flag;
	} res_t;

endpackage

// ===== rtl/mlc_ctrl.sv =====
// ----------------------------------------------------------------------------
// mlc_ctrl
// Sequencer: accepts requests, steps the finish computation and the divider.
// ----------------------------------------------------------------------------
module mlc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic [1:0]       mode,
	input  logic             q_full,
	input  mlc_pkg::status_t status,
	output logic             item_ready,
	output mlc_pkg::cmd_t    cmd
);
	import mlc_pkg::*;

	state_t           state_q, state_d;
	logic [StepW-1:0] step_q;
	logic             take;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// divider step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (state_q == ST_LOAD) begin
			step_q <= '0;
		end else if (state_q == ST_DIV) begin
			step_q <= step_q + StepW'(1);
		end
	end

	assign item_ready = (state_q == ST_IDLE) && !q_full;
	assign take       = item_valid && item_ready;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.take = take;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					if (mode == ModeFinish && !status.count_zero) begin
						state_d = ST_NUM0;
					end else begin
						cmd.push = 1'b1;
					end
				end
			end
			ST_NUM0: begin
				cmd.acc_load = 1'b1;
				cmd.chan_sel = 2'd0;
				cmd.rec_load = 1'b1;
				state_d      = ST_NUM1;
			end
			ST_NUM1: begin
				cmd.acc_add  = 1'b1;
				cmd.chan_sel = 2'd1;
				cmd.den_load = 1'b1;
				state_d      = ST_NUM2;
			end
			ST_NUM2: begin
				cmd.acc_add  = 1'b1;
				cmd.chan_sel = 2'd2;
				state_d      = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.div_load = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == DivLast) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				cmd.finish = 1'b1;
				cmd.push   = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/mlc_dp.sv =====
// ----------------------------------------------------------------------------
// mlc_dp
// Datapath: channel sums, byte count, weighted mean divider and byte mapping.
// ----------------------------------------------------------------------------
module mlc_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  mlc_pkg::cmd_t    cmd,
	input  logic [1:0]       mode,
	input  logic [7:0]       sample,
	input  logic [15:0]      gain,
	output mlc_pkg::status_t status,
	output mlc_pkg::res_t    res
);
	import mlc_pkg::*;

	logic [SumW-1:0]   sum0_q, sum1_q, sum2_q;
	logic [CountW-1:0] count_q;
	logic [1:0]        phase_q;
	logic [MeanW-1:0]  mean_q;

	logic [NumW-1:0]   acc_q;
	logic [RecW-1:0]   rec_q;
	logic [DenW-1:0]   den_q;
	logic [RemW-1:0]   rem_q;
	logic [NumW-1:0]   num_sh_q;
	logic [MeanW-1:0]  quo_q;
	logic              sat_q;

	logic              full;
	logic [SumW-1:0]   mul_a;
	logic [7:0]        mul_b;
	logic [NumW-1:0]   wprod;
	logic [RemW-1:0]   trial;
	logic              ge;
	logic [MeanW-1:0]  mean_new;

	logic signed [10:0] diff;
	logic signed [26:0] aprod;
	logic signed [18:0] ashr;
	logic signed [19:0] asum;
	logic [7:0]         mapped;

	assign full              = (count_q >= MaxBytes);
	assign status.count_zero = (count_q == '0);

	// measurement state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum0_q  <= '0;
			sum1_q  <= '0;
			sum2_q  <= '0;
			count_q <= '0;
			phase_q <= '0;
		end else if (cmd.finish
			|| (cmd.take && mode == ModeFinish && status.count_zero)) begin
			sum0_q  <= '0;
			sum1_q  <= '0;
			sum2_q  <= '0;
			count_q <= '0;
			phase_q <= '0;
		end else if (cmd.take && mode == ModeMeasure && !full) begin
			unique case (phase_q)
				2'd0:    sum0_q <= sum0_q + SumW'(sample);
				2'd1:    sum1_q <= sum1_q + SumW'(sample);
				default: sum2_q <= sum2_q + SumW'(sample);
			endcase
			phase_q <= (phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1;
			count_q <= count_q + CountW'(1);
		end
	end

	// held mean
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q <= MeanReset;
		end else if (cmd.finish) begin
			mean_q <= mean_new;
		end
	end

	// shared weight multiplier
	always_comb begin
		unique case (cmd.chan_sel)
			2'd0: begin
				mul_a = sum0_q;
				mul_b = WeightR;
			end
			2'd1: begin
				mul_a = sum1_q;
				mul_b = WeightG;
			end
			default: begin
				mul_a = sum2_q;
				mul_b = WeightB;
			end
		endcase
	end
	assign wprod = NumW'(mul_a) * NumW'(mul_b);

	// divider step: one quotient bit per cycle
	assign trial    = {rem_q[RemW-2:0], num_sh_q[NumW-1]};
	assign ge       = (trial >= RemW'(den_q));
	assign mean_new = sat_q ? MeanMax : quo_q;

	// finish computation registers
	always_ff @(posedge clk) begin
		if (cmd.acc_load) begin
			acc_q <= wprod;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + wprod;
		end
		if (cmd.rec_load) begin
			rec_q <= RecW'(count_q) * RecW'(Recip3);
		end
		if (cmd.den_load) begin
			den_q <= DenW'(count_q) * DenW'(Mul85) + DenW'(rec_q >> Recip3Shift);
		end
		if (cmd.div_load) begin
			rem_q    <= '0;
			num_sh_q <= acc_q;
			quo_q    <= '0;
			sat_q    <= 1'b0;
		end else if (cmd.div_step) begin
			rem_q    <= ge ? (trial - RemW'(den_q)) : trial;
			num_sh_q <= {num_sh_q[NumW-2:0], 1'b0};
			quo_q    <= {quo_q[MeanW-2:0], ge};
			sat_q    <= sat_q | quo_q[MeanW-1];
		end
	end

	// contrast mapping about the mean
	assign diff  = $signed({3'b000, sample}) - $signed({1'b0, mean_q});
	assign aprod = 27'(diff) * 27'($signed(gain));
	assign ashr  = 19'(aprod >>> 8);
	assign asum  = 20'(ashr) + $signed({10'd0, mean_q});
	always_comb begin
		if (asum < 0) begin
			mapped = 8'd0;
		end else if (asum > 20'sd255) begin
			mapped = 8'd255;
		end else begin
			mapped = asum[7:0];
		end
	end

	// result of this request
	assign res.mapped = (cmd.take && mode == ModeApply) ? mapped : 8'd0;
	assign res.mean   = cmd.finish ? mean_new : mean_q;
	assign res.flag   = cmd.take && ((mode == ModeMeasure && full)
		|| (mode == ModeFinish && status.count_zero));

endmodule

// ===== rtl/mlc_outq.sv =====
// ----------------------------------------------------------------------------
// mlc_outq
// Two-entry result queue between the engine and the result channel.
// ----------------------------------------------------------------------------
module mlc_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mlc_pkg::res_t push_data,
	input  logic          pop,
	output logic          full,
	output logic          valid,
	output mlc_pkg::res_t head
);
	import mlc_pkg::*;

	res_t       slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] fill_q;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end

	// entries
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	assign full  = fill_q[1];
	assign valid = (fill_q != '0);
	assign head  = slot_q[rd_q];

endmodule

// ===== rtl/mean_luminance_contrast.sv =====
// ----------------------------------------------------------------------------
// mean_luminance_contrast
// Two-pass contrast engine: measures weighted mean brightness of an RGB byte
// stream, then maps bytes about that mean by a programmable gain.
// ----------------------------------------------------------------------------
//  channel   handshake                payload
//  item      item_valid/item_ready    mode, sample
//  result    result_valid/result_ready mapped_value, mean_level, empty_flag
//  config    APB psel/penable/pwrite  paddr, pwdata, prdata (contrast_gain @ 0)
//
//  measure, apply and empty finish requests push their result when accepted.
//  a finish with measured bytes passes the three channel sums through the
//  shared weight multiplier, then one divider load, 40 restoring divider steps
//  and a write-back; item_ready stays low meanwhile.
//  a two-entry result queue lets requests flow while a result waits.
//  arst_n clears sums, count, phase, queue; mean returns to 128, gain to 256.
// ----------------------------------------------------------------------------
module mean_luminance_contrast (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [mlc_pkg::AddrW-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  logic [1:0]                mode,
	input  logic [7:0]                sample,
	output logic                      result_valid,
	input  logic                      result_ready,
	output logic [7:0]                mapped_value,
	output logic [9:0]                mean_level,
	output logic                      empty_flag
);
	import mlc_pkg::*;

	logic [15:0] gain_q;
	logic        reg_sel;
	cmd_t        cmd;
	status_t     status;
	res_t        res;
	res_t        head;
	logic        q_full;
	logic        pop;

	// configuration register
	assign pready  = 1'b1;
	assign reg_sel = (paddr[AddrW-1:2] == RegContrastGain);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GainReset;
		end else if (psel && penable && pwrite && reg_sel) begin
			gain_q <= pwdata[15:0];
		end
	end
	assign prdata = reg_sel ? {16'd0, gain_q} : 32'd0;

	mlc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.mode       (mode),
		.q_full     (q_full),
		.status     (status),
		.item_ready (item_ready),
		.cmd        (cmd)
	);

	mlc_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.mode   (mode),
		.sample (sample),
		.gain   (gain_q),
		.status (status),
		.res    (res)
	);

	assign pop = result_valid && result_ready;

	mlc_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd.push),
		.push_data (res),
		.pop       (pop),
		.full      (q_full),
		.valid     (result_valid),
		.head      (head)
	);

	assign mapped_value = head.mapped;
	assign mean_level   = head.mean;
	assign empty_flag   = head.flag;

	// a result is never pushed into a full queue
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !q_full)
		else $error("result pushed into full queue");

	// a finish with measured bytes holds off the next request
	a_finish_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && mode == ModeFinish && !status.count_zero) |=> !item_ready)
		else $error("request accepted during finish computation");

	// every accepted request except a long finish pushes its result at once
	a_take_push: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && !(mode == ModeFinish && !status.count_zero)) |-> cmd.push)
		else $error("accepted request produced no result");

	// after a finish the measurement restarts from an empty count
	a_finish_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> status.count_zero)
		else $error("count not cleared after finish");

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mean luminance contrast engine. A directed table
// covers reset values, empty and partial measurements and the pixel extremes;
// random image passes (measure, finish, apply) then run under several gain
// settings written over the register port. Every accepted request is run
// through a behavioral predictor, and results are compared in order, field by
// field. Both sides of the stream stall in random bursts.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mlc_pkg::*;

	localparam logic [1:0]       ModeUnused  = 2'd3;
	localparam logic [AddrW-1:0] GainAddr    = {RegContrastGain, 2'b00};
	localparam int               WatchLimit  = 2000;
	localparam int               DrainCycles = 60;
	localparam int               PhaseItems  = 148;
	localparam int               NumPhases   = 8;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] pix;
		logic       known;
		res_t       want;
	} row_t;

	localparam logic Known = 1'b1;
	localparam logic Free  = 1'b0;
	localparam res_t NoRes = '0;

	// directed rows; typed results only where obvious from reset state
	localparam int   DirN = 22;
	localparam row_t DirRows [DirN] = '{
		'{ModeUnused,  8'd255, Known, '{8'd0,   10'd128, 1'b0}},
		'{ModeFinish,  8'd0,   Known, '{8'd0,   10'd128, 1'b1}},
		'{ModeApply,   8'd0,   Known, '{8'd0,   10'd128, 1'b0}},
		'{ModeApply,   8'd255, Known, '{8'd255, 10'd128, 1'b0}},
		'{ModeApply,   8'd128, Known, '{8'd128, 10'd128, 1'b0}},
		'{ModeMeasure, 8'd255, Known, '{8'd0,   10'd128, 1'b0}},
		// single byte, partial triple
		'{ModeFinish,  8'd0,   Free,  NoRes},
		'{ModeApply,   8'd0,   Free,  NoRes},
		'{ModeApply,   8'd255, Free,  NoRes},
		// two bytes, mean above the pixel range
		'{ModeMeasure, 8'd0,   Free,  NoRes},
		'{ModeMeasure, 8'd255, Free,  NoRes},
		'{ModeFinish,  8'd170, Free,  NoRes},
		'{ModeApply,   8'd1,   Free,  NoRes},
		'{ModeApply,   8'd254, Free,  NoRes},
		// full white triple
		'{ModeMeasure, 8'd255, Free,  NoRes},
		'{ModeMeasure, 8'd255, Free,  NoRes},
		'{ModeMeasure, 8'd255, Free,  NoRes},
		'{ModeFinish,  8'd0,   Free,  NoRes},
		'{ModeApply,   8'd200, Free,  NoRes},
		'{ModeUnused,  8'd0,   Free,  NoRes},
		'{ModeFinish,  8'd85,  Free,  NoRes},
		'{ModeApply,   8'd255, Free,  NoRes}
	};

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [AddrW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid;
	logic        item_ready;
	logic [1:0]  mode;
	logic [7:0]  sample;
	logic        result_valid;
	logic        result_ready;
	logic [7:0]  mapped_value;
	logic [9:0]  mean_level;
	logic        empty_flag;

	// typed expectation travels with the request
	logic        req_known;
	res_t        req_want;

	// predictor state
	logic [31:0]        sum_r      = '0;
	logic [31:0]        sum_g      = '0;
	logic [31:0]        sum_b      = '0;
	logic [CountW-1:0]  byte_total = '0;
	logic [1:0]         chan_phase = '0;
	logic [MeanW-1:0]   mean_q     = MeanReset;
	logic signed [15:0] gain_q     = GainReset;

	res_t pending_results [$];
	res_t got;
	res_t want;
	int   fail_count  = 0;
	int   quiet_cycles = 0;
	bit   calm        = 1'b0;
	int   gap_pct     = 10;

	mean_luminance_contrast i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.mode         (mode),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.mapped_value (mapped_value),
		.mean_level   (mean_level),
		.empty_flag   (empty_flag)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// next result of the engine for one request, advancing the predictor
	function automatic res_t luma_step(input logic [1:0] op, input logic [7:0] pix);
		res_t        r;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] quo;
		int          mean_i;
		int          g;
		int          prod;
		int          level;
		r = '0;
		case (op)
		ModeMeasure: begin
			if (byte_total >= MaxBytes) begin
				r.flag = 1'b1;
			end else begin
				case (chan_phase)
				2'd0:    sum_r += 32'(pix);
				2'd1:    sum_g += 32'(pix);
				default: sum_b += 32'(pix);
				endcase
				chan_phase = (chan_phase == 2'd2) ? 2'd0 : chan_phase + 2'd1;
				byte_total = byte_total + 1'b1;
			end
		end
		ModeFinish: begin
			if (byte_total == '0) begin
				r.flag = 1'b1;
			end else begin
				num = 64'(sum_r) * 64'(WeightR) + 64'(sum_g) * 64'(WeightG)
					+ 64'(sum_b) * 64'(WeightB);
				den = (64'(byte_total) * 64'd256) / 64'd3;
				quo = num / den;
				mean_q = (quo > 64'(MeanMax)) ? MeanMax : quo[MeanW-1:0];
			end
			sum_r = '0;
			sum_g = '0;
			sum_b = '0;
			byte_total = '0;
			chan_phase = '0;
		end
		ModeApply: begin
			mean_i = int'(mean_q);
			g = gain_q;
			prod = (int'(pix) - mean_i) * g;
			level = (prod >>> 8) + mean_i;
			if (level < 0)
				level = 0;
			else if (level > 255)
				level = 255;
			r.mapped = level[7:0];
		end
		default: ;
		endcase
		r.mean = mean_q;
		return r;
	endfunction

	task automatic check_field(input string what, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, what, exp_v, act_v);
		end
	endtask

	// scoreboard, register shadow and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			quiet_cycles++;
			if (psel && penable && pwrite && pready) begin
				gain_q = pwdata[15:0];
				quiet_cycles = 0;
			end
			if (result_valid && result_ready) begin
				quiet_cycles = 0;
				if (pending_results.size() == 0) begin
					fail_count++;
					$display("%0t: result with nothing expected, mapped %0d mean %0d flag %0d",
						$time, mapped_value, mean_level, empty_flag);
				end else begin
					want = pending_results.pop_front();
					check_field("mapped_value", want.mapped, mapped_value);
					check_field("mean_level", want.mean, mean_level);
					check_field("empty_flag", want.flag, empty_flag);
				end
			end
			if (item_valid && item_ready) begin
				quiet_cycles = 0;
				got = luma_step(mode, sample);
				pending_results.push_back(req_known ? req_want : got);
			end
			if (quiet_cycles >= WatchLimit) begin
				$display("%0t: no progress for %0d cycles", $time, WatchLimit);
				$display("mean_luminance_contrast verification failed");
				$finish;
			end
		end
	end

	// result side back-pressure
	initial begin
		result_ready = 1'b0;
		repeat (3) @(posedge clk);
		forever begin
			if (calm || $urandom_range(0, 2) != 0) begin
				result_ready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end else begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
		end
	end

	// one request, with an optional idle burst ahead of it
	task automatic send_request(input logic [1:0] op, input logic [7:0] pix,
		input logic known, input res_t exp_r);
		if ($urandom_range(0, 63) == 0)
			gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		item_valid <= 1'b1;
		mode       <= op;
		sample     <= pix;
		req_known  <= known;
		req_want   <= exp_r;
		do @(posedge clk); while (!item_ready);
	endtask

	// drop valid and wait for every outstanding result
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic gain_write(input logic [15:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= GainAddr;
		pwdata  <= {{16{value[15]}}, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic gain_readback();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= GainAddr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("contrast_gain readback", gain_q, $signed(prdata[15:0]));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic logic [7:0] pixel_byte();
		case ($urandom_range(0, 15))
		0:       return 8'd0;
		1:       return 8'd255;
		default: return 8'($urandom);
		endcase
	endfunction

	// random image passes; ignored requests are not counted
	task automatic image_phase(input int budget);
		int done;
		int kind;
		int len;
		int k;
		done = 0;
		while (done < budget) begin
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 90) : $urandom_range(1, 24);
				for (k = 0; k < len; k++)
					send_request(ModeMeasure, pixel_byte(), Free, NoRes);
				send_request(ModeFinish, 8'($urandom), Free, NoRes);
				done += len + 1;
				len = $urandom_range(1, 12);
				for (k = 0; k < len; k++)
					send_request(ModeApply, pixel_byte(), Free, NoRes);
				done += len;
			end else if (kind < 85) begin
				len = $urandom_range(1, 8);
				for (k = 0; k < len; k++)
					send_request(ModeApply, pixel_byte(), Free, NoRes);
				done += len;
			end else if (kind < 93) begin
				send_request(ModeFinish, 8'($urandom), Free, NoRes);
				done++;
			end else begin
				send_request(ModeUnused, 8'($urandom), Free, NoRes);
			end
		end
	endtask

	// main sequence
	initial begin
		logic [15:0] gain_pick;
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		item_valid = 1'b0;
		mode       = ModeMeasure;
		sample     = '0;
		req_known  = Free;
		req_want   = NoRes;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gain_readback();

		for (int i = 0; i < DirN; i++)
			send_request(DirRows[i].op, DirRows[i].pix, DirRows[i].known, DirRows[i].want);

		// gain sweep: extremes, zero, identity, inversion, a fixed 0x02bc boost, random
		for (int ph = 0; ph < NumPhases; ph++) begin
			case (ph)
			0:       gain_pick = 16'h7fff;
			1:       gain_pick = 16'h8000;
			2:       gain_pick = 16'h0000;
			3:       gain_pick = 16'h0100;
			4:       gain_pick = 16'hff00;
			6:       gain_pick = 16'h02bc;
			default: gain_pick = 16'($urandom);
			endcase
			if (ph == NumPhases - 1)
				calm = 1'b1;
			settle();
			gain_write(gain_pick);
			gain_readback();
			image_phase(PhaseItems);
		end

		settle();
		repeat (DrainCycles) @(posedge clk);
		if (fail_count == 0)
			$display("mean_luminance_contrast verification clean");
		else
			$display("mean_luminance_contrast verification failed");
		$finish;
	end

endmodule
